@@ design/bms_pkg.sv @@
// Shared types and constants of the binned moment sum block.
package bms_pkg;

  // Store geometry
  localparam int NumBins = 1024;
  localparam int AddrW   = $clog2(NumBins);

  // Field widths fixed by the item format
  localparam int FuncW   = 2;
  localparam int BinW    = 10;
  localparam int ValueW  = 64;
  localparam int MomentW = 4;
  localparam int HalfW   = ValueW / 2;

  // Operation codes
  localparam logic [FuncW-1:0] FuncAccumulate = 2'd0;
  localparam logic [FuncW-1:0] FuncRead       = 2'd1;
  localparam logic [FuncW-1:0] FuncMerge      = 2'd2;

  localparam logic [MomentW-1:0] MomentReset = 4'd1;

  typedef struct packed {
    logic [FuncW-1:0]         func;
    logic [BinW-1:0]          bin;
    logic signed [ValueW-1:0] value;
    logic                     include_req;
  } bms_in_t;

  typedef struct packed {
    logic [BinW-1:0]          bin_out;
    logic signed [ValueW-1:0] sum;
  } bms_out_t;

  // Power unit request and response
  typedef struct packed {
    logic               start;
    logic [ValueW-1:0]  base;
    logic [MomentW-1:0] moment;
  } bms_pow_req_t;

  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] result;
  } bms_pow_rsp_t;

endpackage

@@ design/bms_if.sv @@
// Request and result channel interfaces of the binned moment sum block.
interface bms_in_if
  import bms_pkg::*;
();
  logic    valid;
  logic    ready;
  bms_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bms_out_if
  import bms_pkg::*;
();
  logic     valid;
  logic     ready;
  bms_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/bms_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bms_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ design/bms_power.sv @@
// Iterative wrapping power unit built around one shared 32x32 multiplier.
module bms_power
  import bms_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bms_pow_req_t req_i,
  output bms_pow_rsp_t rsp_o
);

  typedef enum logic [0:0] {PwIdle, PwRun} pw_state_e;

  pw_state_e          state_q;
  logic [1:0]         phase_q;
  logic [MomentW-1:0] cnt_q;
  logic               done_q;
  logic [ValueW-1:0]  base_q;
  logic [ValueW-1:0]  res_q;
  logic [ValueW-1:0]  acc_q;

  logic [HalfW-1:0]  mul_a;
  logic [HalfW-1:0]  mul_b;
  logic [ValueW-1:0] prod;
  logic [ValueW-1:0] prod_shl;

  // The low 64 bits of a 64x64 product take three partial products; the
  // high-by-high term falls entirely above bit 63 and is dropped.
  always_comb begin
    case (phase_q)
      2'd0: begin
        mul_a = res_q[HalfW-1:0];
        mul_b = base_q[HalfW-1:0];
      end
      2'd1: begin
        mul_a = res_q[HalfW-1:0];
        mul_b = base_q[ValueW-1:HalfW];
      end
      default: begin
        mul_a = res_q[ValueW-1:HalfW];
        mul_b = base_q[HalfW-1:0];
      end
    endcase
  end

  assign prod     = {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};
  assign prod_shl = {prod[HalfW-1:0], {HalfW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PwIdle;
      phase_q <= 2'd0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        PwIdle: begin
          if (req_i.start) begin
            base_q  <= req_i.base;
            phase_q <= 2'd0;
            state_q <= PwRun;
            if (req_i.moment == '0) begin
              res_q <= ValueW'(1);
              cnt_q <= '0;
            end else begin
              res_q <= req_i.base;
              cnt_q <= req_i.moment - MomentW'(1);
            end
          end
        end
        PwRun: begin
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= PwIdle;
          end else begin
            case (phase_q)
              2'd0: begin
                acc_q   <= prod;
                phase_q <= 2'd1;
              end
              2'd1: begin
                acc_q   <= acc_q + prod_shl;
                phase_q <= 2'd2;
              end
              default: begin
                res_q   <= acc_q + prod_shl;
                cnt_q   <= cnt_q - MomentW'(1);
                phase_q <= 2'd0;
              end
            endcase
          end
        end
        default: state_q <= PwIdle;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

@@ design/binned_moment_sum_top.sv @@
// Top level of the binned moment sum block: bin store, sequencer and output register.
//
// The block keeps 1024 signed 64-bit bin sums in a RAM with one write and one read port
// and handles one request at a time. After reset it writes zero to every bin and
// takes no request meanwhile. The moment register may be written while no request is
// in work, including during the clearing pass. A read may wait for the output to
// drain, and an accumulate waits for the iterative power unit, which runs three
// multiplier passes per power step. Skipped samples and unknown operations leave the
// store untouched. Each read and read-modify-write goes through the RAM's registered
// read. A finished read result waits in the output register while the next request
// is already taken.
module binned_moment_sum_top
  import bms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MomentW-1:0] cfg_wdata_i,
  bms_in_if.sink             in_i,
  bms_out_if.source          out_o
);

  typedef enum logic [2:0] {
    StClear, StIdle, StPowGo, StPowWait, StRead, StUpdate, StDeliver
  } state_e;

  state_e             state_q;
  logic [AddrW-1:0]   clr_q;
  logic [MomentW-1:0] moment_q;
  logic [FuncW-1:0]   func_q;
  logic [BinW-1:0]    bin_q;
  logic [ValueW-1:0]  value_q;
  logic [ValueW-1:0]  operand_q;
  logic [ValueW-1:0]  sum_q;
  logic               out_valid_q;
  bms_out_t           out_q;

  logic               in_range;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [ValueW-1:0]  ram_wdata;
  logic               ram_re;
  logic [ValueW-1:0]  ram_rdata;
  bms_pow_req_t       pow_req;
  bms_pow_rsp_t       pow_rsp;

  assign in_range = (32'(in_i.data.bin) < NumBins);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moment_q <= MomentReset;
    end else if (cfg_we_i) begin
      moment_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // While delivering, the output register is handled in the state arm below.
      if (out_o.ready && state_q != StDeliver) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          clr_q <= clr_q + AddrW'(1);
          if (32'(clr_q) == NumBins - 1) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_i.valid) begin
            func_q  <= in_i.data.func;
            bin_q   <= in_i.data.bin;
            value_q <= in_i.data.value;
            case (in_i.data.func)
              FuncAccumulate: begin
                if (in_i.data.include_req && in_range) begin
                  state_q <= StPowGo;
                end
              end
              FuncMerge: begin
                if (in_range) begin
                  operand_q <= in_i.data.value;
                  state_q   <= StRead;
                end
              end
              FuncRead: begin
                if (in_range) begin
                  state_q <= StRead;
                end else begin
                  sum_q   <= '0;
                  state_q <= StDeliver;
                end
              end
              default: state_q <= StIdle;
            endcase
          end
        end
        StPowGo: state_q <= StPowWait;
        StPowWait: begin
          if (pow_rsp.done) begin
            operand_q <= pow_rsp.result;
            state_q   <= StRead;
          end
        end
        StRead: state_q <= StUpdate;
        StUpdate: begin
          if (func_q == FuncRead) begin
            sum_q   <= ram_rdata;
            state_q <= StDeliver;
          end else begin
            state_q <= StIdle;
          end
        end
        StDeliver: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.bin_out <= bin_q;
            out_q.sum     <= sum_q;
            out_valid_q   <= 1'b1;
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // The clearing pass and the write-back of a request share the one write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bin_q[AddrW-1:0];
    ram_wdata = ram_rdata + operand_q;
    if (state_q == StClear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == StUpdate && func_q != FuncRead) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = (state_q == StRead);

  assign pow_req.start  = (state_q == StPowGo);
  assign pow_req.base   = value_q;
  assign pow_req.moment = moment_q;

  bms_ram #(
    .Width(ValueW),
    .Depth(NumBins)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(bin_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  bms_power u_power (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (pow_req),
    .rsp_o (pow_rsp)
  );

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

@@ design/bms_checker.sv @@
// Port-level checks of the binned moment sum block and their binding to the top level.
module bms_checker
  import bms_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input bms_in_t  in_data_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input bms_out_t out_data_i
);

  // A result that is not taken stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  // Reads and merges always touch the store, so taking one closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
    (in_data_i.func == FuncRead || in_data_i.func == FuncMerge) |=> !in_ready_i)
    else $error("request taken while the previous one is still in work");

  // A new result only appears once the sequencer has been busy with a read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a read in work");

endmodule

bind binned_moment_sum_top bms_checker u_bms_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_data_i  (in_i.data),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

@@ tb/moment_sum_checker.sv @@
// Checker for the binned moment sum block: predicts every read result and compares it.
module moment_sum_checker
  import bms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MomentW-1:0] cfg_wdata_i,
  bms_in_if                  req_mon_i,
  bms_out_if                 rsp_mon_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [ValueW-1:0]  bin_totals [NumBins];
  logic [MomentW-1:0] moment_q;
  bms_out_t           expected_reads [$];
  int                 failures;

  function automatic logic [ValueW-1:0] raise_to_moment(input logic [ValueW-1:0] base,
                                                        input logic [MomentW-1:0] power);
    logic [ValueW-1:0] acc;
    int                step;
    acc = 1;
    for (step = 0; step < int'(power); step++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    bms_in_t  req;
    bms_out_t want;
    bms_out_t got;
    int       idx;
    if (!rst_ni) begin
      for (idx = 0; idx < NumBins; idx++) begin
        bin_totals[idx] = '0;
      end
      moment_q = MomentReset;
      expected_reads.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        moment_q = cfg_wdata_i;
      end

      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        got = rsp_mon_i.data;
        if (expected_reads.size() == 0) begin
          failures++;
          $display("%0t: result with no read request pending: expected none, %s %0d sum %0d",
                   $time, "got bin", got.bin_out, got.sum);
        end else begin
          want = expected_reads.pop_front();
          if (got.bin_out !== want.bin_out) begin
            failures++;
            $display("%0t: bin_out mismatch: expected %0d, got %0d",
                     $time, want.bin_out, got.bin_out);
          end
          if (got.sum !== want.sum) begin
            failures++;
            $display("%0t: sum mismatch for bin %0d: expected %0d, got %0d",
                     $time, want.bin_out, want.sum, got.sum);
          end
        end
      end

      if (req_mon_i.valid && req_mon_i.ready) begin
        req = req_mon_i.data;
        idx = int'(req.bin);
        case (req.func)
          FuncAccumulate: begin
            if (idx < NumBins && req.include_req) begin
              bin_totals[idx] = bin_totals[idx] + raise_to_moment(req.value, moment_q);
            end
          end
          FuncMerge: begin
            if (idx < NumBins) begin
              bin_totals[idx] = bin_totals[idx] + req.value;
            end
          end
          FuncRead: begin
            want.bin_out = req.bin;
            want.sum     = (idx < NumBins) ? bin_totals[idx] : '0;
            expected_reads.push_back(want);
          end
          default: ;
        endcase
      end

      fail_count_o <= failures;
      pending_o <= expected_reads.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the binned moment sum testbench: clock, reset, request stimulus and verdict.
module tb_top;
  import bms_pkg::*;

  localparam logic [FuncW-1:0]         FuncUnused    = 2'd3;
  localparam logic signed [ValueW-1:0] MaxValue      = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic signed [ValueW-1:0] MinValue      = {1'b1, {(ValueW-1){1'b0}}};
  localparam int                       WatchdogLimit = 5000;
  localparam int                       DrainCycles   = 64;
  localparam int                       NumPhases     = 8;
  localparam int                       PhaseItems    = 130;
  localparam int                       BlockItems    = 32;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [MomentW-1:0] cfg_wdata;
  bit                 sender_idle_on;
  bit                 stall_on;
  int                 fail_count;
  int                 pending_reads;
  int                 quiet_cycles;

  logic [MomentW-1:0] phase_moments [NumPhases] =
    '{4'd0, 4'd15, 4'd2, 4'd1, 4'd3, 4'd15, 4'd7, 4'd0};

  bms_in_if  req_if ();
  bms_out_if rsp_if ();

  binned_moment_sum_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  moment_sum_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon_i    (req_if),
    .rsp_mon_i    (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_reads)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic bms_in_t make_request(input logic [FuncW-1:0] func,
                                           input int bin,
                                           input logic [ValueW-1:0] value,
                                           input logic inc);
    bms_in_t r;
    r.func        = func;
    r.bin         = BinW'(bin);
    r.value       = value;
    r.include_req = inc;
    return r;
  endfunction

  function automatic bms_in_t random_request();
    bms_in_t r;
    int      pick;
    int      small_val;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      r.func = FuncAccumulate;
    end else if (pick < 14) begin
      r.func = FuncRead;
    end else if (pick < 19) begin
      r.func = FuncMerge;
    end else begin
      r.func = FuncUnused;
    end
    // Most requests hit a handful of bins so that reads see long histories.
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      r.bin = BinW'($urandom_range(0, 7));
    end else if (pick == 6) begin
      r.bin = '0;
    end else if (pick == 7) begin
      r.bin = '1;
    end else begin
      r.bin = BinW'($urandom);
    end
    small_val = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 5))
      0: r.value = {{HalfW{small_val[31]}}, small_val};
      1: begin
        case ($urandom_range(0, 3))
          0: r.value = MaxValue;
          1: r.value = MinValue;
          2: r.value = '1;
          default: r.value = '0;
        endcase
      end
      2: r.value = ValueW'($urandom_range(0, 1000));
      default: r.value = {$urandom, $urandom};
    endcase
    r.include_req = ($urandom_range(0, 4) != 0);
    return r;
  endfunction

  task automatic send_request(input bms_in_t req);
    if (sender_idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Holds requests back until every read result is in and any accumulate has finished.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_moment(input logic [MomentW-1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: ready drops in bursts while stalling is switched on.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               p;
    int               k;
    logic [MomentW-1:0] m;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    sender_idle_on = 1'b0;
    stall_on       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset moment of one.
    send_request(make_request(FuncRead, 0, '0, 1'b0));
    send_request(make_request(FuncAccumulate, 0, MaxValue, 1'b1));
    send_request(make_request(FuncAccumulate, 0, MinValue, 1'b1));
    send_request(make_request(FuncRead, 0, '0, 1'b0));
    send_request(make_request(FuncAccumulate, 0, 64'd123, 1'b0));
    send_request(make_request(FuncUnused, 0, 64'd99, 1'b1));
    send_request(make_request(FuncRead, 0, '1, 1'b1));
    send_request(make_request(FuncMerge, 1023, MaxValue, 1'b0));
    send_request(make_request(FuncMerge, 1023, MaxValue, 1'b1));
    send_request(make_request(FuncRead, 1023, '0, 1'b0));
    send_request(make_request(FuncMerge, 1023, MinValue, 1'b0));
    send_request(make_request(FuncRead, 1023, '0, 1'b0));
    send_request(make_request(FuncAccumulate, 1023, '1, 1'b1));
    send_request(make_request(FuncRead, 1023, MaxValue, 1'b1));
    send_request(make_request(FuncRead, 512, '1, 1'b1));
    send_request(make_request(FuncUnused, 1023, MaxValue, 1'b0));
    send_request(make_request(FuncAccumulate, 512, MinValue, 1'b1));
    send_request(make_request(FuncMerge, 512, '1, 1'b0));
    send_request(make_request(FuncRead, 512, '0, 1'b0));
    send_request(make_request(FuncRead, 1023, '0, 1'b0));

    for (p = 0; p < NumPhases; p++) begin
      settle();
      m = (p == NumPhases - 2) ? MomentW'($urandom_range(0, 15)) : phase_moments[p];
      write_moment(m);
      for (k = 0; k < PhaseItems; k++) begin
        if (k % BlockItems == 0) begin
          sender_idle_on = (p != NumPhases - 1) && ($urandom_range(0, 3) != 0);
          stall_on <= (p != NumPhases - 1) && ($urandom_range(0, 3) != 0);
        end
        if (p != NumPhases - 1 && $urandom_range(0, 59) == 0) begin
          settle();
        end
        send_request(random_request());
      end
    end

    settle();
    if (fail_count == 0 && pending_reads == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bms_pkg.sv
design/bms_if.sv
design/bms_ram.sv
design/bms_power.sv
design/binned_moment_sum_top.sv
design/bms_checker.sv
tb/moment_sum_checker.sv
tb/tb_top.sv
